@@ src/csev_pkg.sv @@
// Shared types and codes for the cubic spline evaluator.
`timescale 1ns / 1ps

package csev_pkg;

    typedef enum logic
    {
        MODE_CATMULL = 1'b0,
        MODE_HERMITE = 1'b1
    } curve_mode_t;

    // Control that travels beside each item's payload from stage to stage.
    typedef struct packed
    {
        logic        valid;
        curve_mode_t mode;
    } stage_ctrl_t;

endpackage

@@ src/csev_power.sv @@
// Two pipeline stages that form t squared and t cubed, rounded to the parameter grid.
`timescale 1ns / 1ps

module csev_power #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  csev_pkg::stage_ctrl_t              in_ctrl,
    input  logic [PARAM_FRAC_BITS:0]           in_t,
    input  logic signed [COORD_WIDTH-1:0]      in_coord [4],
    output csev_pkg::stage_ctrl_t              out_ctrl,
    output logic [PARAM_FRAC_BITS:0]           out_t,
    output logic [PARAM_FRAC_BITS:0]           out_t2,
    output logic [PARAM_FRAC_BITS:0]           out_t3,
    output logic signed [COORD_WIDTH-1:0]      out_coord [4]
);
    import csev_pkg::*;

    localparam int TW = PARAM_FRAC_BITS + 1;
    localparam int PW = 2 * TW;
    localparam logic [PW-1:0] Half = PW'(1) << (PARAM_FRAC_BITS - 1);

    stage_ctrl_t                  sq_ctrl_reg;
    logic [TW-1:0]                sq_t_reg;
    logic [TW-1:0]                sq_t2_reg;
    logic signed [COORD_WIDTH-1:0] sq_coord_reg [4];

    stage_ctrl_t                  cb_ctrl_reg;
    logic [TW-1:0]                cb_t_reg;
    logic [TW-1:0]                cb_t2_reg;
    logic [TW-1:0]                cb_t3_reg;
    logic signed [COORD_WIDTH-1:0] cb_coord_reg [4];

    logic [PW-1:0] sq_prod;
    logic [PW-1:0] cb_prod;
    logic [TW-1:0] sq_t2_next;
    logic [TW-1:0] cb_t3_next;

    // Round half up, then drop the fraction bits of the doubled product.
    always_comb
    begin
        sq_prod    = PW'(in_t) * PW'(in_t) + Half;
        sq_t2_next = sq_prod[PARAM_FRAC_BITS +: TW];
        cb_prod    = PW'(sq_t2_reg) * PW'(sq_t_reg) + Half;
        cb_t3_next = cb_prod[PARAM_FRAC_BITS +: TW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctrl_reg <= '{valid: 1'b0, mode: MODE_CATMULL};
            cb_ctrl_reg <= '{valid: 1'b0, mode: MODE_CATMULL};
        end
        else if (en)
        begin
            sq_ctrl_reg <= in_ctrl;
            cb_ctrl_reg <= sq_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_t_reg     <= in_t;
            sq_t2_reg    <= sq_t2_next;
            sq_coord_reg <= in_coord;
            cb_t_reg     <= sq_t_reg;
            cb_t2_reg    <= sq_t2_reg;
            cb_t3_reg    <= cb_t3_next;
            cb_coord_reg <= sq_coord_reg;
        end
    end

    assign out_ctrl  = cb_ctrl_reg;
    assign out_t     = cb_t_reg;
    assign out_t2    = cb_t2_reg;
    assign out_t3    = cb_t3_reg;
    assign out_coord = cb_coord_reg;

endmodule

@@ src/csev_weights.sv @@
// Basis weight stage: Catmull-Rom (doubled) or cubic Hermite weights from t, t^2, t^3.
`timescale 1ns / 1ps

module csev_weights #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  csev_pkg::stage_ctrl_t               in_ctrl,
    input  logic [PARAM_FRAC_BITS:0]            in_t,
    input  logic [PARAM_FRAC_BITS:0]            in_t2,
    input  logic [PARAM_FRAC_BITS:0]            in_t3,
    input  logic signed [COORD_WIDTH-1:0]       in_coord [4],
    output csev_pkg::stage_ctrl_t               out_ctrl,
    output logic signed [PARAM_FRAC_BITS+4:0]   out_weight [4],
    output logic signed [COORD_WIDTH-1:0]       out_coord [4]
);
    import csev_pkg::*;

    // Every weight stays within eight times one, so four integer bits and a sign suffice.
    localparam int WW = PARAM_FRAC_BITS + 5;
    localparam logic signed [WW-1:0] OneW = WW'(1) <<< PARAM_FRAC_BITS;

    stage_ctrl_t                   ctrl_reg;
    logic signed [WW-1:0]          weight_reg [4];
    logic signed [WW-1:0]          weight_next [4];
    logic signed [COORD_WIDTH-1:0] coord_reg [4];

    logic signed [WW-1:0] t1;
    logic signed [WW-1:0] t2;
    logic signed [WW-1:0] t3;

    always_comb
    begin
        t1 = signed'(WW'(in_t));
        t2 = signed'(WW'(in_t2));
        t3 = signed'(WW'(in_t3));
        unique case (in_ctrl.mode)
            MODE_HERMITE:
            begin
                weight_next[0] = (t3 <<< 1) - ((t2 <<< 1) + t2) + OneW;
                weight_next[1] = t3 - (t2 <<< 1) + t1;
                weight_next[2] = ((t2 <<< 1) + t2) - (t3 <<< 1);
                weight_next[3] = t3 - t2;
            end
            default:
            begin
                weight_next[0] = (t2 <<< 1) - t3 - t1;
                weight_next[1] = ((t3 <<< 1) + t3) - ((t2 <<< 2) + t2) + (OneW <<< 1);
                weight_next[2] = (t2 <<< 2) - ((t3 <<< 1) + t3) + t1;
                weight_next[3] = t3 - t2;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{valid: 1'b0, mode: MODE_CATMULL};
        end
        else if (en)
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= weight_next;
            coord_reg  <= in_coord;
        end
    end

    assign out_ctrl   = ctrl_reg;
    assign out_weight = weight_reg;
    assign out_coord  = coord_reg;

endmodule

@@ src/csev_blend.sv @@
// Blend stages: four products, adder tree with rounding, shift and saturation to the output.
`timescale 1ns / 1ps

module csev_blend #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  csev_pkg::stage_ctrl_t               in_ctrl,
    input  logic signed [PARAM_FRAC_BITS+4:0]   in_weight [4],
    input  logic signed [COORD_WIDTH-1:0]       in_coord [4],
    output logic                                out_valid,
    output logic signed [COORD_WIDTH-1:0]       out_value,
    output logic                                out_sat
);
    import csev_pkg::*;

    localparam int WW = PARAM_FRAC_BITS + 5;
    localparam int PW = WW + COORD_WIDTH;
    localparam int SW = PW + 2;
    localparam int HW = SW - COORD_WIDTH + 1;
    localparam logic signed [SW-1:0] RndHermite = SW'(1) <<< (PARAM_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] RndCatmull = SW'(1) <<< PARAM_FRAC_BITS;
    localparam logic signed [COORD_WIDTH-1:0] MaxVal = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MinVal = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    stage_ctrl_t          mul_ctrl_reg;
    logic signed [PW-1:0] prod_reg [4];
    stage_ctrl_t          pair_ctrl_reg;
    logic signed [SW-1:0] pair_lo_reg;
    logic signed [SW-1:0] pair_hi_reg;
    stage_ctrl_t          sum_ctrl_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 out_valid_reg;
    logic signed [COORD_WIDTH-1:0] value_reg;
    logic                 sat_reg;

    logic signed [PW-1:0] prod_next [4];
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] shifted;
    logic [HW-1:0]        high_bits;
    logic signed [COORD_WIDTH-1:0] value_next;
    logic                 sat_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = PW'(in_weight[i]) * PW'(in_coord[i]);
        end
        sum_next = pair_lo_reg + pair_hi_reg
                   + ((pair_ctrl_reg.mode == MODE_HERMITE) ? RndHermite : RndCatmull);
    end

    // Floor shift; Catmull-Rom drops one more bit to halve its doubled weights.
    always_comb
    begin
        if (sum_ctrl_reg.mode == MODE_HERMITE)
        begin
            shifted = sum_reg >>> PARAM_FRAC_BITS;
        end
        else
        begin
            shifted = sum_reg >>> (PARAM_FRAC_BITS + 1);
        end
        high_bits = shifted[SW-1:COORD_WIDTH-1];
        if ((high_bits == '0) || (high_bits == '1))
        begin
            value_next = shifted[COORD_WIDTH-1:0];
            sat_next   = 1'b0;
        end
        else
        begin
            value_next = shifted[SW-1] ? MinVal : MaxVal;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ctrl_reg  <= '{valid: 1'b0, mode: MODE_CATMULL};
            pair_ctrl_reg <= '{valid: 1'b0, mode: MODE_CATMULL};
            sum_ctrl_reg  <= '{valid: 1'b0, mode: MODE_CATMULL};
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_ctrl_reg  <= in_ctrl;
            pair_ctrl_reg <= mul_ctrl_reg;
            sum_ctrl_reg  <= pair_ctrl_reg;
            out_valid_reg <= sum_ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            pair_lo_reg <= SW'(prod_reg[0]) + SW'(prod_reg[1]);
            pair_hi_reg <= SW'(prod_reg[2]) + SW'(prod_reg[3]);
            sum_reg     <= sum_next;
            value_reg   <= value_next;
            sat_reg     <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = value_reg;
    assign out_sat   = sat_reg;

endmodule

@@ src/cubic_spline_evaluator_core.sv @@
// A result shows on m_tvalid once its request has passed all eight register stages.
// Throughput: one request per cycle; eight register stages advance together and
// hold as one whenever the output register is full and m_tready is low.
// Reset (rst_n, asynchronous, active low) empties every stage and sets curve_mode
// to Catmull-Rom; the configuration channel is always ready.
`timescale 1ns / 1ps

module cubic_spline_evaluator_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int InBits = PARAM_FRAC_BITS + 1 + 4 * COORD_WIDTH,
    localparam int InW    = ((InBits + 7) / 8) * 8,
    localparam int OutW   = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  logic            clk,
    input  logic            rst_n,
    // Configuration write: curve_mode (0 Catmull-Rom, 1 cubic Hermite)
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,
    // Request stream
    input  logic            s_tvalid,
    output logic            s_tready,
    // s_tdata, lowest bit up: blend_param, ctrl_first, ctrl_second,
    // ctrl_third, ctrl_fourth, zero fill
    input  logic [InW-1:0]  s_tdata,
    // Result stream
    output logic            m_tvalid,
    input  logic            m_tready,
    // m_tdata, lowest bit up: curve_value, zero fill
    output logic [OutW-1:0] m_tdata,
    // m_tuser: saturated
    output logic [0:0]      m_tuser
);
    import csev_pkg::*;

    localparam int TW = PARAM_FRAC_BITS + 1;
    localparam int WW = PARAM_FRAC_BITS + 5;
    localparam logic [TW-1:0] ParamOne = TW'(1) << PARAM_FRAC_BITS;

    curve_mode_t curve_mode_reg;

    // Entry stage: clamped parameter and the four control values.
    stage_ctrl_t                   in_ctrl_reg;
    logic [TW-1:0]                 in_t_reg;
    logic signed [COORD_WIDTH-1:0] in_coord_reg [4];

    logic                          en;
    logic                          accept;
    logic [TW-1:0]                 t_raw;
    logic [TW-1:0]                 t_clamped;
    logic signed [COORD_WIDTH-1:0] coord_in [4];
    stage_ctrl_t                   in_ctrl_next;

    stage_ctrl_t                   pw_ctrl;
    logic [TW-1:0]                 pw_t;
    logic [TW-1:0]                 pw_t2;
    logic [TW-1:0]                 pw_t3;
    logic signed [COORD_WIDTH-1:0] pw_coord [4];

    stage_ctrl_t                   wt_ctrl;
    logic signed [WW-1:0]          wt_weight [4];
    logic signed [COORD_WIDTH-1:0] wt_coord [4];

    logic                          bl_valid;
    logic signed [COORD_WIDTH-1:0] bl_value;
    logic                          bl_sat;

    // Advance the whole pipe unless a finished result waits on a stalled sink.
    assign en       = !bl_valid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg <= MODE_CATMULL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            curve_mode_reg <= curve_mode_t'(cfg_data);
        end
    end

    // Unpack the request and clamp a parameter above one down to one.
    always_comb
    begin
        t_raw = s_tdata[TW-1:0];
        if (t_raw[PARAM_FRAC_BITS] && (t_raw[PARAM_FRAC_BITS-1:0] != '0))
        begin
            t_clamped = ParamOne;
        end
        else
        begin
            t_clamped = t_raw;
        end
        for (int i = 0; i < 4; i++)
        begin
            coord_in[i] = s_tdata[TW + i * COORD_WIDTH +: COORD_WIDTH];
        end
        // Each request carries the mode it was accepted under.
        in_ctrl_next.valid = accept;
        in_ctrl_next.mode  = curve_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg <= '{valid: 1'b0, mode: MODE_CATMULL};
        end
        else if (en)
        begin
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_t_reg     <= t_clamped;
            in_coord_reg <= coord_in;
        end
    end

    // Stages two and three: t squared, then t cubed.
    csev_power #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctrl   (in_ctrl_reg),
        .in_t      (in_t_reg),
        .in_coord  (in_coord_reg),
        .out_ctrl  (pw_ctrl),
        .out_t     (pw_t),
        .out_t2    (pw_t2),
        .out_t3    (pw_t3),
        .out_coord (pw_coord)
    );

    // Stage four: basis weights for the selected curve type.
    csev_weights #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_weights (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_ctrl    (pw_ctrl),
        .in_t       (pw_t),
        .in_t2      (pw_t2),
        .in_t3      (pw_t3),
        .in_coord   (pw_coord),
        .out_ctrl   (wt_ctrl),
        .out_weight (wt_weight),
        .out_coord  (wt_coord)
    );

    // Stages five to eight: products, pair sums, rounded total, saturated output register.
    csev_blend #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctrl   (wt_ctrl),
        .in_weight (wt_weight),
        .in_coord  (wt_coord),
        .out_valid (bl_valid),
        .out_value (bl_value),
        .out_sat   (bl_sat)
    );

    assign m_tvalid   = bl_valid;
    assign m_tdata    = OutW'($unsigned(bl_value));
    assign m_tuser[0] = bl_sat;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the cubic spline evaluator core.
`timescale 1ns / 1ps

module tb_top;

    import csev_pkg::*;

    localparam longint PARAM_ONE  = 64'sd65536;
    localparam longint PARAM_HALF = 64'sd32768;
    localparam longint COORD_MAX  = 64'sd2147483647;
    localparam longint COORD_MIN  = -64'sd2147483648;

    localparam logic [16:0]        T_ZERO = 17'h00000;
    localparam logic [16:0]        T_HALF = 17'h08000;
    localparam logic [16:0]        T_ONE  = 17'h10000;
    localparam logic signed [31:0] CMAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN   = 32'sh8000_0000;

    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 325;

    // One blended coordinate as the core should return it.
    typedef struct packed
    {
        logic signed [31:0] curve_value;
        logic               saturated;
    } point_result_t;

    // One directed request; known marks a row whose result is typed in.
    typedef struct packed
    {
        curve_mode_t        mode;
        logic [16:0]        t;
        logic signed [31:0] pa;
        logic signed [31:0] pb;
        logic signed [31:0] pc;
        logic signed [31:0] pd;
        logic               known;
        logic signed [31:0] want_value;
        logic               want_sat;
    } spline_row_t;

    // Directed requests: ends of t, clamping of t above one, extreme control
    // values and overflow in both directions, in both curve modes.
    spline_row_t directed_rows [21] = '{
        // Catmull-Rom: t = 0 gives point b, t = 1 gives point c
        '{MODE_CATMULL, T_ZERO, 32'sh0001_0000, 32'sh0003_8000, 32'sh0000_0000,
          32'sh0000_0000, 1'b1, 32'sh0003_8000, 1'b0},
        '{MODE_CATMULL, T_ZERO, CMIN, CMAX, CMIN, CMAX, 1'b1, CMAX, 1'b0},
        '{MODE_CATMULL, T_ZERO, CMAX, CMIN, CMAX, CMIN, 1'b1, CMIN, 1'b0},
        '{MODE_CATMULL, T_ONE, CMIN, CMIN, CMAX, CMIN, 1'b1, CMAX, 1'b0},
        '{MODE_CATMULL, 17'h1FFFF, 32'sh0000_1234, 32'sh0007_0000, 32'shFFFE_C000,
          32'sh0100_0000, 1'b1, 32'shFFFE_C000, 1'b0},
        '{MODE_CATMULL, 17'h10001, CMAX, CMAX, CMIN, CMAX, 1'b1, CMIN, 1'b0},
        // overshoot at t = 0.5 drives the sum past either end
        '{MODE_CATMULL, T_HALF, CMIN, CMAX, CMAX, CMIN, 1'b1, CMAX, 1'b1},
        '{MODE_CATMULL, T_HALF, CMAX, CMIN, CMIN, CMAX, 1'b1, CMIN, 1'b1},
        '{MODE_CATMULL, T_HALF, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 32'sh0, 1'b0},
        '{MODE_CATMULL, 17'h00001, 32'sh0002_0000, 32'shFFFF_0001, 32'sh0004_8000,
          32'sh7FFF_0000, 1'b0, 32'sh0, 1'b0},
        '{MODE_CATMULL, 17'h0FFFF, 32'sh0002_0000, 32'shFFFF_0001, 32'sh0004_8000,
          32'sh7FFF_0000, 1'b0, 32'sh0, 1'b0},
        '{MODE_CATMULL, 17'h04000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0000_0003,
          32'shFFFF_FFFD, 1'b0, 32'sh0, 1'b0},
        // Hermite: t = 0 gives the start point, t = 1 the end point
        '{MODE_HERMITE, T_ZERO, CMIN, CMAX, CMAX, CMAX, 1'b1, CMIN, 1'b0},
        '{MODE_HERMITE, T_ZERO, CMAX, CMIN, CMIN, CMIN, 1'b1, CMAX, 1'b0},
        '{MODE_HERMITE, T_ONE, CMAX, CMAX, 32'shFFFF_FFF9, CMIN, 1'b1,
          32'shFFFF_FFF9, 1'b0},
        '{MODE_HERMITE, 17'h1FFFF, CMIN, CMIN, CMAX, CMAX, 1'b1, CMAX, 1'b0},
        // steep tangents push the midpoint out of range
        '{MODE_HERMITE, T_HALF, CMAX, CMAX, CMAX, CMIN, 1'b1, CMAX, 1'b1},
        '{MODE_HERMITE, T_HALF, CMIN, CMIN, CMIN, CMAX, 1'b1, CMIN, 1'b1},
        '{MODE_HERMITE, T_HALF, 32'sh0001_0000, 32'shFFF0_0000, 32'sh0005_4321,
          32'sh0020_0000, 1'b0, 32'sh0, 1'b0},
        '{MODE_HERMITE, 17'h00001, 32'sh1234_5678, 32'sh7654_3210, 32'shEDCB_A987,
          32'sh89AB_CDEF, 1'b0, 32'sh0, 1'b0},
        '{MODE_CATMULL, 17'h0C000, 32'sh0003_0000, 32'sh0001_0000, 32'shFFFC_0000,
          32'sh0000_8001, 1'b0, 32'sh0, 1'b0}
    };

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data  = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // s_tdata, lowest bit up: blend_param, ctrl_first, ctrl_second,
    // ctrl_third, ctrl_fourth, zero fill
    logic [151:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b1;
    // m_tdata, lowest bit up: curve_value
    logic [31:0]  m_tdata;
    // m_tuser: saturated
    logic [0:0]   m_tuser;

    point_result_t pending_points [$];
    curve_mode_t   active_mode = MODE_CATMULL;
    int            mismatches  = 0;
    bit            calm_tail   = 1'b0;

    cubic_spline_evaluator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Blend four control values at parameter t; the sum is exact in 64 bits
    // and rounding happens at t squared, t cubed and the final shift only.
    function automatic point_result_t blend_point(input curve_mode_t mode,
                                                  input logic [16:0] t_raw,
                                                  input logic signed [31:0] pa,
                                                  input logic signed [31:0] pb,
                                                  input logic signed [31:0] pc,
                                                  input logic signed [31:0] pd);
        longint        t;
        longint        t2;
        longint        t3;
        longint        wa;
        longint        wb;
        longint        wc;
        longint        wd;
        longint        acc;
        longint        q;
        int            sh;
        point_result_t r;
        t  = (longint'(t_raw) > PARAM_ONE) ? PARAM_ONE : longint'(t_raw);
        t2 = (t * t + PARAM_HALF) >>> 16;
        t3 = (t2 * t + PARAM_HALF) >>> 16;
        if (mode == MODE_HERMITE)
        begin
            wa = 2 * t3 - 3 * t2 + PARAM_ONE;
            wb = t3 - 2 * t2 + t;
            wc = 3 * t2 - 2 * t3;
            wd = t3 - t2;
            sh = 16;
        end
        else
        begin
            // Catmull-Rom weights are doubled; the halving rides in the shift
            wa = 2 * t2 - t3 - t;
            wb = 3 * t3 - 5 * t2 + 2 * PARAM_ONE;
            wc = 4 * t2 - 3 * t3 + t;
            wd = t3 - t2;
            sh = 17;
        end
        acc = wa * longint'(pa) + wb * longint'(pb) + wc * longint'(pc)
            + wd * longint'(pd);
        q   = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
        r.saturated = 1'b0;
        if (q > COORD_MAX)
        begin
            q           = COORD_MAX;
            r.saturated = 1'b1;
        end
        else if (q < COORD_MIN)
        begin
            q           = COORD_MIN;
            r.saturated = 1'b1;
        end
        r.curve_value = q[31:0];
        return r;
    endfunction

    function automatic logic [16:0] pick_param();
        case ($urandom_range(0, 15))
            0:       return T_ZERO;
            1:       return T_ONE;
            2:       return 17'($urandom_range(65537, 131071));
            3:       return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_coord();
        logic signed [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 11))
            0:       return CMAX;
            1:       return CMIN;
            2, 3, 4: return raw;
            // mostly modest coordinates, within about +/-8.0
            default: return raw >>> 12;
        endcase
    endfunction

    // Offer one request, hold it until accepted, then record its result.
    // Drop valid for a random burst now and then while the run is not calm.
    task automatic send_request(input logic [16:0] t,
                                input logic signed [31:0] pa,
                                input logic signed [31:0] pb,
                                input logic signed [31:0] pc,
                                input logic signed [31:0] pd,
                                input point_result_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pd, pc, pb, pa, t};
        do
            @(posedge clk);
        while (!s_tready);
        pending_points.push_back(want);
        if (!calm_tail && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Drain the pipeline, then write curve_mode while the core is idle.
    task automatic write_curve_mode(input curve_mode_t mode);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        active_mode  = mode;
    endtask

    initial
    begin : drive_requests
        point_result_t want;
        logic [16:0]   t;
        logic signed [31:0] pa;
        logic signed [31:0] pb;
        logic signed [31:0] pc;
        logic signed [31:0] pd;
        curve_mode_t   phase_mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: switch modes only where a row asks for the other one
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != active_mode)
                write_curve_mode(directed_rows[i].mode);
            if (directed_rows[i].known)
            begin
                want.curve_value = directed_rows[i].want_value;
                want.saturated   = directed_rows[i].want_sat;
            end
            else
                want = blend_point(active_mode, directed_rows[i].t,
                                   directed_rows[i].pa, directed_rows[i].pb,
                                   directed_rows[i].pc, directed_rows[i].pd);
            send_request(directed_rows[i].t, directed_rows[i].pa,
                         directed_rows[i].pb, directed_rows[i].pc,
                         directed_rows[i].pd, want);
        end

        // Random part: alternate modes per phase, last phase without idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            phase_mode = (ph % 2 == 0) ? MODE_HERMITE : MODE_CATMULL;
            write_curve_mode(phase_mode);
            if (ph == RANDOM_PHASES - 1)
                calm_tail = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                t    = pick_param();
                pa   = pick_coord();
                pb   = pick_coord();
                pc   = pick_coord();
                pd   = pick_coord();
                want = blend_point(active_mode, t, pa, pb, pc, pd);
                send_request(t, pa, pb, pc, pd, want);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        // Hold a little past the pipeline depth to catch stray results
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("** cubic_spline_evaluator_core: PASSED **");
        else
            $display("** cubic_spline_evaluator_core: FAILED **");
        $finish;
    end

    // Stall the result side in random bursts until the calm tail.
    initial
    begin : stall_results
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm_tail && $urandom_range(0, 11) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        point_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected result: curve_value %h saturated %b",
                       m_tdata, m_tuser[0]);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata[31:0] !== want.curve_value)
                begin
                    $error("curve_value: expected %h, got %h",
                           want.curve_value, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tuser[0] !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b",
                           want.saturated, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Give up well beyond the slowest legal run.
    initial
    begin : watchdog
        #5_000_000;
        $display("** cubic_spline_evaluator_core: FAILED **");
        $finish;
    end

endmodule

@@ cubic_spline_evaluator_core.f @@
src/csev_pkg.sv
src/csev_power.sv
src/csev_weights.sv
src/csev_blend.sv
src/cubic_spline_evaluator_core.sv
tb/sv/tb_top.sv
